### sv/echo_presence_qualifier_assert.svh
// assertion macros shared by the echo presence qualifier checker
`ifndef ECHO_PRESENCE_QUALIFIER_ASSERT_SVH
`define ECHO_PRESENCE_QUALIFIER_ASSERT_SVH

// same-cycle implication, disabled while reset is asserted
`define EPQ_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("epq assertion failed");

// next-cycle implication, disabled while reset is asserted
`define EPQ_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("epq assertion failed");

`endif

### sv/epq_pkg.sv
// shared types, constants and helpers of the echo presence qualifier
package epq_pkg;

    localparam int ECHO_W          = 15;
    localparam int TIME_W          = 32;
    localparam int CFG_W           = 16;
    localparam int APB_ADDR_W      = 5;
    localparam int APB_DATA_W      = 32;
    localparam int EPQ_QUEUE_DEPTH = 2;

    // register reset values (distances in cm times 58)
    localparam logic [CFG_W-1:0] MIN_ECHO_RST      = 16'd116;
    localparam logic [CFG_W-1:0] DETECT_ECHO_RST   = 16'd8700;
    localparam logic [CFG_W-1:0] OUTSIDE_ECHO_RST  = 16'd9860;
    localparam logic [CFG_W-1:0] MAX_ECHO_RST      = 16'd23200;
    localparam logic [CFG_W-1:0] PRESENCE_CONF_RST = 16'd1000;
    localparam logic [CFG_W-1:0] GRACE_TIME_RST    = 16'd250;
    localparam logic [CFG_W-1:0] CLEAR_CONF_RST    = 16'd1000;

    typedef enum logic [2:0] {
        CLS_ZONE    = 3'd0,
        CLS_BORDER  = 3'd1,
        CLS_OUTSIDE = 3'd2,
        CLS_NOECHO  = 3'd3,
        CLS_INVALID = 3'd4
    } epq_class_t;

    typedef enum logic [2:0] {
        REG_MIN_ECHO      = 3'd0,
        REG_DETECT_ECHO   = 3'd1,
        REG_OUTSIDE_ECHO  = 3'd2,
        REG_MAX_ECHO      = 3'd3,
        REG_PRESENCE_CONF = 3'd4,
        REG_GRACE_TIME    = 3'd5,
        REG_CLEAR_CONF    = 3'd6
    } epq_reg_t;

    typedef struct packed {
        logic [ECHO_W-1:0] echo_width;
        logic [TIME_W-1:0] now_time;
    } epq_in_t;

    typedef struct packed {
        logic [2:0]        reading_class;
        logic              zone_occupied;
        logic              area_is_clear;
        logic              just_confirmed;
        logic              just_cleared;
        logic [TIME_W-1:0] presence_time;
        logic [TIME_W-1:0] clear_time;
    } epq_out_t;

    typedef struct packed {
        logic [CFG_W-1:0] min_echo;
        logic [CFG_W-1:0] detect_echo;
        logic [CFG_W-1:0] outside_echo;
        logic [CFG_W-1:0] max_echo;
        logic [CFG_W-1:0] presence_confirm_time;
        logic [CFG_W-1:0] no_echo_grace_time;
        logic [CFG_W-1:0] clear_confirm_time;
    } epq_cfg_t;

    // classified reading handed from front to back
    typedef struct packed {
        epq_class_t        cls;
        logic [TIME_W-1:0] elapsed;
        logic              zone_pair;
        logic              clear_pair;
        logic              gap_expired;
    } epq_evt_t;

    function automatic logic is_clear_evidence(epq_class_t c);
        return (c == CLS_OUTSIDE) || (c == CLS_NOECHO);
    endfunction

    function automatic logic [TIME_W-1:0] sat_add(logic [TIME_W-1:0] a,
                                                  logic [TIME_W-1:0] b);
        logic [TIME_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[TIME_W] ? {TIME_W{1'b1}} : s[TIME_W-1:0];
    endfunction

endpackage

### sv/echo_presence_qualifier.sv
// top level of the echo presence qualifier: register file, front, queue, back
//
//  channel | direction | handshake         | payload
//  --------+-----------+-------------------+-----------------------------------
//  s_      | in        | s_valid / s_ready | epq_in_t: echo_width, now_time
//  m_      | out       | m_valid / m_ready | epq_out_t: class, flags, accumulators
//  apb     | in        | psel/penable      | paddr[4:2] register, pwdata[15:0]
//
// one reading per cycle sustained while m_ready stays high; m_valid rises once the
// event has passed the queue (written at the transfer edge) and the output register
// the back end updates its accumulators once per popped event, which sets the rate
// reset is synchronous and active low; configuration registers return to their defaults
// a stalled m_ channel fills the queue, then s_ready drops until it drains
module echo_presence_qualifier #(
    parameter int QUEUE_DEPTH = epq_pkg::EPQ_QUEUE_DEPTH
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  epq_pkg::epq_in_t               s_data,
    output logic                           m_valid,
    input  logic                           m_ready,
    output epq_pkg::epq_out_t              m_data,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [epq_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [epq_pkg::APB_DATA_W-1:0] pwdata,
    output logic [epq_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready
);
    import epq_pkg::*;

    epq_cfg_t   cfg_reg, cfg_next;
    epq_reg_t   reg_sel;
    logic       cfg_write;
    logic       push_valid, queue_full, pop, pop_valid;
    epq_evt_t   push_data, pop_data;

    // configuration port
    assign pready    = 1'b1;
    assign reg_sel   = epq_reg_t'(paddr[4:2]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_write) begin
            case (reg_sel)
                REG_MIN_ECHO:      cfg_next.min_echo              = pwdata[CFG_W-1:0];
                REG_DETECT_ECHO:   cfg_next.detect_echo           = pwdata[CFG_W-1:0];
                REG_OUTSIDE_ECHO:  cfg_next.outside_echo          = pwdata[CFG_W-1:0];
                REG_MAX_ECHO:      cfg_next.max_echo              = pwdata[CFG_W-1:0];
                REG_PRESENCE_CONF: cfg_next.presence_confirm_time = pwdata[CFG_W-1:0];
                REG_GRACE_TIME:    cfg_next.no_echo_grace_time    = pwdata[CFG_W-1:0];
                REG_CLEAR_CONF:    cfg_next.clear_confirm_time    = pwdata[CFG_W-1:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    // register readback
    always_comb begin
        case (reg_sel)
            REG_MIN_ECHO:      prdata = APB_DATA_W'(cfg_reg.min_echo);
            REG_DETECT_ECHO:   prdata = APB_DATA_W'(cfg_reg.detect_echo);
            REG_OUTSIDE_ECHO:  prdata = APB_DATA_W'(cfg_reg.outside_echo);
            REG_MAX_ECHO:      prdata = APB_DATA_W'(cfg_reg.max_echo);
            REG_PRESENCE_CONF: prdata = APB_DATA_W'(cfg_reg.presence_confirm_time);
            REG_GRACE_TIME:    prdata = APB_DATA_W'(cfg_reg.no_echo_grace_time);
            REG_CLEAR_CONF:    prdata = APB_DATA_W'(cfg_reg.clear_confirm_time);
            default:           prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.min_echo              <= MIN_ECHO_RST;
            cfg_reg.detect_echo           <= DETECT_ECHO_RST;
            cfg_reg.outside_echo          <= OUTSIDE_ECHO_RST;
            cfg_reg.max_echo              <= MAX_ECHO_RST;
            cfg_reg.presence_confirm_time <= PRESENCE_CONF_RST;
            cfg_reg.no_echo_grace_time    <= GRACE_TIME_RST;
            cfg_reg.clear_confirm_time    <= CLEAR_CONF_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // classify and time-stamp readings
    epq_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .queue_full (queue_full),
        .push_valid (push_valid),
        .push_data  (push_data)
    );

    // decoupling queue
    epq_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_data  (push_data),
        .full       (queue_full),
        .pop        (pop),
        .pop_valid  (pop_valid),
        .pop_data   (pop_data)
    );

    // evidence accumulation and result register
    epq_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .pop_valid (pop_valid),
        .pop_data  (pop_data),
        .pop       (pop),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

### sv/epq_front.sv
// front end: accepts readings, classifies them and tracks timing history
module epq_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  epq_pkg::epq_cfg_t cfg,
    input  logic              s_valid,
    output logic              s_ready,
    input  epq_pkg::epq_in_t  s_data,
    input  logic              queue_full,
    output logic              push_valid,
    output epq_pkg::epq_evt_t push_data
);
    import epq_pkg::*;

    epq_class_t        last_class_reg, last_class_next;
    logic [TIME_W-1:0] last_time_reg, last_time_next;
    logic [TIME_W-1:0] gap_start_reg, gap_start_next;

    epq_class_t        cls;
    logic [CFG_W-1:0]  width_ext;
    logic [TIME_W-1:0] gap_base;
    logic [TIME_W-1:0] gap_len;

    // handshake with the queue
    assign s_ready    = !queue_full;
    assign push_valid = s_valid && s_ready;

    // zone classification, checked in priority order
    always_comb begin
        width_ext = {1'b0, s_data.echo_width};
        if (width_ext == '0) begin
            cls = CLS_NOECHO;
        end else if (width_ext < cfg.min_echo || width_ext > cfg.max_echo) begin
            cls = CLS_INVALID;
        end else if (width_ext <= cfg.detect_echo) begin
            cls = CLS_ZONE;
        end else if (width_ext < cfg.outside_echo) begin
            cls = CLS_BORDER;
        end else begin
            cls = CLS_OUTSIDE;
        end
    end

    // no-echo run length against the grace time
    assign gap_base = (last_class_reg != CLS_NOECHO) ? s_data.now_time : gap_start_reg;
    assign gap_len  = s_data.now_time - gap_base;

    // event for the back end
    always_comb begin
        push_data.cls         = cls;
        push_data.elapsed     = s_data.now_time - last_time_reg;
        push_data.zone_pair   = (last_class_reg == CLS_ZONE) && (cls == CLS_ZONE);
        push_data.clear_pair  = is_clear_evidence(last_class_reg) && is_clear_evidence(cls);
        push_data.gap_expired = (cls == CLS_NOECHO) &&
                                (gap_len > {{(TIME_W-CFG_W){1'b0}}, cfg.no_echo_grace_time});
    end

    // history update on each input transfer
    always_comb begin
        last_class_next = last_class_reg;
        last_time_next  = last_time_reg;
        gap_start_next  = gap_start_reg;
        if (push_valid) begin
            last_class_next = cls;
            last_time_next  = s_data.now_time;
            case (cls)
                CLS_NOECHO: gap_start_next = gap_base;
                CLS_BORDER: gap_start_next = gap_start_reg;
                default:    gap_start_next = '0;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_class_reg <= CLS_INVALID;
            last_time_reg  <= '0;
            gap_start_reg  <= '0;
        end else begin
            last_class_reg <= last_class_next;
            last_time_reg  <= last_time_next;
            gap_start_reg  <= gap_start_next;
        end
    end

endmodule

### sv/epq_queue.sv
// small register queue between front and back
module epq_queue #(
    parameter int DEPTH = epq_pkg::EPQ_QUEUE_DEPTH
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push_valid,
    input  epq_pkg::epq_evt_t push_data,
    output logic              full,
    input  logic              pop,
    output logic              pop_valid,
    output epq_pkg::epq_evt_t pop_data
);
    import epq_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    epq_evt_t         entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_data  = entry_reg[rd_ptr_reg];
    assign do_push   = push_valid && !full;
    assign do_pop    = pop && pop_valid;

    // pointer and fill count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

### sv/epq_back.sv
// back end: accumulates evidence, confirms presence and clearance
module epq_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  epq_pkg::epq_cfg_t cfg,
    input  logic              pop_valid,
    input  epq_pkg::epq_evt_t pop_data,
    output logic              pop,
    output logic              m_valid,
    input  logic              m_ready,
    output epq_pkg::epq_out_t m_data
);
    import epq_pkg::*;

    logic              present_reg, present_next;
    logic              clear_reg, clear_next;
    logic [TIME_W-1:0] pacc_reg, pacc_next;
    logic [TIME_W-1:0] cacc_reg, cacc_next;
    logic              m_valid_reg, m_valid_next;
    epq_out_t          m_data_reg, m_data_next;

    logic [TIME_W-1:0] pacc_sum, cacc_sum;
    logic              jconf, jclr;

    // take an event when the output register is free or draining
    assign pop     = pop_valid && (!m_valid_reg || m_ready);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // time added while consecutive readings agree
    assign pacc_sum = pop_data.zone_pair  ? sat_add(pacc_reg, pop_data.elapsed) : pacc_reg;
    assign cacc_sum = pop_data.clear_pair ? sat_add(cacc_reg, pop_data.elapsed) : cacc_reg;

    // presence and clearance decisions
    always_comb begin
        present_next = present_reg;
        clear_next   = clear_reg;
        pacc_next    = pacc_reg;
        cacc_next    = cacc_reg;
        jconf        = 1'b0;
        jclr         = 1'b0;
        if (pop) begin
            pacc_next = pacc_sum;
            cacc_next = cacc_sum;
            case (pop_data.cls)
                CLS_ZONE: begin
                    cacc_next  = '0;
                    clear_next = 1'b0;
                    if (!present_reg &&
                        pacc_sum >= {{(TIME_W-CFG_W){1'b0}}, cfg.presence_confirm_time}) begin
                        present_next = 1'b1;
                        jconf        = 1'b1;
                    end
                end
                CLS_NOECHO, CLS_OUTSIDE: begin
                    if (pop_data.cls == CLS_OUTSIDE || pop_data.gap_expired) begin
                        pacc_next    = '0;
                        present_next = 1'b0;
                    end
                    if (!clear_reg &&
                        cacc_sum >= {{(TIME_W-CFG_W){1'b0}}, cfg.clear_confirm_time}) begin
                        present_next = 1'b0;
                        clear_next   = 1'b1;
                        jclr         = 1'b1;
                    end
                    // outside alone never drops a confirmed presence
                    if (pop_data.cls == CLS_OUTSIDE && !jclr) begin
                        present_next = present_reg;
                    end
                end
                CLS_INVALID: begin
                    pacc_next = '0;
                    cacc_next = '0;
                end
                default: begin
                end
            endcase
        end
    end

    // output register
    always_comb begin
        m_data_next                = m_data_reg;
        m_data_next.reading_class  = pop_data.cls;
        m_data_next.zone_occupied  = present_next;
        m_data_next.area_is_clear  = clear_next;
        m_data_next.just_confirmed = jconf;
        m_data_next.just_cleared   = jclr;
        m_data_next.presence_time  = pacc_next;
        m_data_next.clear_time     = cacc_next;
        if (pop) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            present_reg <= 1'b0;
            clear_reg   <= 1'b0;
            pacc_reg    <= '0;
            cacc_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            present_reg <= present_next;
            clear_reg   <= clear_next;
            pacc_reg    <= pacc_next;
            cacc_reg    <= cacc_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            m_data_reg <= m_data_next;
        end
    end

endmodule

### sv/epq_checker.sv
// port-level checker of the echo presence qualifier and its bind
`include "echo_presence_qualifier_assert.svh"

module epq_checker (
    input logic              aclk,
    input logic              aresetn,
    input logic              m_valid,
    input logic              m_ready,
    input epq_pkg::epq_out_t m_data
);
    import epq_pkg::*;

    logic conf_shown, conf_flags;
    logic clr_shown, clr_flags;
    logic invalid_shown, accs_empty;

    // result conditions watched below
    assign conf_shown    = m_valid && m_data.just_confirmed;
    assign conf_flags    = m_data.zone_occupied && !m_data.area_is_clear;
    assign clr_shown     = m_valid && m_data.just_cleared;
    assign clr_flags     = m_data.area_is_clear && !m_data.zone_occupied;
    assign invalid_shown = m_valid && (m_data.reading_class == CLS_INVALID);
    assign accs_empty    = (m_data.presence_time == '0) && (m_data.clear_time == '0);

    // a stalled result transfer holds
    `EPQ_ASSERT_NXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data))

    // a fresh confirmation leaves presence set
    `EPQ_ASSERT_IMP(a_conf_present, aclk, aresetn, conf_shown, conf_flags)

    // a fresh clearance drops presence
    `EPQ_ASSERT_IMP(a_clr_flags, aclk, aresetn, clr_shown, clr_flags)

    // an invalid reading empties both accumulators
    `EPQ_ASSERT_IMP(a_invalid_acc, aclk, aresetn, invalid_shown, accs_empty)

endmodule

bind echo_presence_qualifier epq_checker u_epq_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
